// ===== rtl/core/cpcr_pkg.sv =====
`default_nettype none

package cpcr_pkg;

   localparam int unsigned SqrtSteps = 32;
   localparam int unsigned DivSteps = 31;

   typedef struct packed {
      logic signed [31:0] pax;
      logic signed [31:0] pay;
      logic signed [31:0] vax;
      logic signed [31:0] vay;
      logic signed [31:0] pbx;
      logic signed [31:0] pby;
      logic signed [31:0] vbx;
      logic signed [31:0] vby;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] rvx;
      logic signed [32:0] rvy;
      logic [31:0]        sumr;
      logic               ok;
   } pair_type;

   typedef struct packed {
      pair_type    pair;
      logic [63:0] rad;
      logic [32:0] rem;
      logic [31:0] root;
   } sqrt_type;

   typedef struct packed {
      pair_type    pair;
      logic [31:0] distance;
      logic [31:0] rem_x;
      logic [31:0] rem_y;
      logic        nbit_x;
      logic        nbit_y;
      logic [30:0] q_x;
      logic [30:0] q_y;
   } div_type;

   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      logic signed [31:0] r;
      if (v > 37'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -37'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/circle_pair_collision_response.sv =====
`default_nettype none

// Resolves one pair of equal-mass circles per request; positions and velocities are
// signed Q16.16, radii unsigned. Fully pipelined: a new request can be taken every
// clock while req_stall is low. The pipeline holds the 32-step square root
// and the 31-step normal divider, one bit per stage each. When the result output
// is held by rsp_stall the whole pipeline holds and req_stall rises.

module circle_pair_collision_response (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_pos_a_x,
   input  wire logic signed [31:0] req_pos_a_y,
   input  wire logic signed [31:0] req_vel_a_x,
   input  wire logic signed [31:0] req_vel_a_y,
   input  wire logic        [30:0] req_radius_a,
   input  wire logic signed [31:0] req_pos_b_x,
   input  wire logic signed [31:0] req_pos_b_y,
   input  wire logic signed [31:0] req_vel_b_x,
   input  wire logic signed [31:0] req_vel_b_y,
   input  wire logic        [30:0] req_radius_b,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_new_pos_a_x,
   output logic signed [31:0]      rsp_new_pos_a_y,
   output logic signed [31:0]      rsp_new_vel_a_x,
   output logic signed [31:0]      rsp_new_vel_a_y,
   output logic signed [31:0]      rsp_new_pos_b_x,
   output logic signed [31:0]      rsp_new_pos_b_y,
   output logic signed [31:0]      rsp_new_vel_b_x,
   output logic signed [31:0]      rsp_new_vel_b_y,
   output logic                    rsp_collided
);

   localparam int unsigned NSq = cpcr_pkg::SqrtSteps;
   localparam int unsigned NDv = cpcr_pkg::DivSteps;

   typedef struct packed {
      cpcr_pkg::pair_type pair;
      logic [63:0]        sx;
      logic [63:0]        sy;
   } sq_type;

   typedef struct packed {
      cpcr_pkg::pair_type pair;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [64:0] px;
      logic signed [64:0] py;
      logic signed [33:0] ov;
   } dot_type;

   typedef struct packed {
      cpcr_pkg::pair_type pair;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [35:0] vn;
      logic signed [33:0] ov;
      logic               hit;
   } vn_type;

   typedef struct packed {
      cpcr_pkg::pair_type pair;
      logic signed [67:0] mvx;
      logic signed [67:0] mvy;
      logic signed [65:0] mox;
      logic signed [65:0] moy;
      logic               hit;
   } prod_type;

   typedef struct packed {
      cpcr_pkg::pair_type pair;
      logic signed [35:0] dvx;
      logic signed [35:0] dvy;
      logic signed [33:0] shx;
      logic signed [33:0] shy;
      logic               hit;
   } delta_type;

   logic en;

   cpcr_pkg::pair_type a_in, a_ff;
   logic               a_v_ff;
   sq_type             b_in, b_ff;
   logic               b_v_ff;

   cpcr_pkg::sqrt_type sq_data [0:NSq];
   logic               sq_valid [0:NSq];
   cpcr_pkg::div_type  dv_data [0:NDv];
   logic               dv_valid [0:NDv];

   cpcr_pkg::sqrt_type c_in, c_ff;
   logic               c_v_ff;
   cpcr_pkg::div_type  d_in, d_ff;
   logic               d_v_ff;
   dot_type            e_in, e_ff;
   logic               e_v_ff;
   vn_type             f_in, f_ff;
   logic               f_v_ff;
   prod_type           g_in, g_ff;
   logic               g_v_ff;
   delta_type          h_in, h_ff;
   logic               h_v_ff;

   logic [31:0]        adx, ady, bdx, bdy;
   logic [64:0]        d2;
   logic signed [65:0] dot;
   logic signed [65:0] dot_rnd;
   logic signed [67:0] mvx_rnd, mvy_rnd;
   logic signed [65:0] mox_rnd, moy_rnd;
   logic signed [31:0] o_pax, o_pay, o_vax, o_vay, o_pbx, o_pby, o_vbx, o_vby;

   logic               rsp_valid_ff;
   logic signed [31:0] pax_ff, pay_ff, vax_ff, vay_ff, pbx_ff, pby_ff, vbx_ff, vby_ff;
   logic               col_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // differences and radius sum
   always_comb begin
      a_in.pax  = req_pos_a_x;
      a_in.pay  = req_pos_a_y;
      a_in.vax  = req_vel_a_x;
      a_in.vay  = req_vel_a_y;
      a_in.pbx  = req_pos_b_x;
      a_in.pby  = req_pos_b_y;
      a_in.vbx  = req_vel_b_x;
      a_in.vby  = req_vel_b_y;
      a_in.dx   = {req_pos_b_x[31], req_pos_b_x} - {req_pos_a_x[31], req_pos_a_x};
      a_in.dy   = {req_pos_b_y[31], req_pos_b_y} - {req_pos_a_y[31], req_pos_a_y};
      a_in.rvx  = {req_vel_b_x[31], req_vel_b_x} - {req_vel_a_x[31], req_vel_a_x};
      a_in.rvy  = {req_vel_b_y[31], req_vel_b_y} - {req_vel_a_y[31], req_vel_a_y};
      a_in.sumr = {1'b0, req_radius_a} + {1'b0, req_radius_b};
      a_in.ok   = 1'b0;
   end

   // squares
   always_comb begin
      adx     = a_ff.dx[32] ? 32'(-a_ff.dx) : a_ff.dx[31:0];
      ady     = a_ff.dy[32] ? 32'(-a_ff.dy) : a_ff.dy[31:0];
      b_in.pair = a_ff;
      b_in.sx   = 64'(adx) * 64'(adx);
      b_in.sy   = 64'(ady) * 64'(ady);
   end

   // squared distance, overflow and zero check
   always_comb begin
      d2           = {1'b0, b_ff.sx} + {1'b0, b_ff.sy};
      c_in.pair    = b_ff.pair;
      c_in.pair.ok = !d2[64] && (d2[63:0] != 64'd0);
      c_in.rad     = d2[63:0];
      c_in.rem     = '0;
      c_in.root    = '0;
   end

   assign sq_data[0]  = c_ff;
   assign sq_valid[0] = c_v_ff;

   for (genvar i = 0; i < NSq; i++) begin : g_sqrt
      cpcr_sqrt_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_valid[i]),
         .in_data   (sq_data[i]),
         .out_valid (sq_valid[i+1]),
         .out_data  (sq_data[i+1])
      );
   end

   // contact test and divider setup
   always_comb begin
      bdx = sq_data[NSq].pair.dx[32] ? 32'(-sq_data[NSq].pair.dx)
                                     : sq_data[NSq].pair.dx[31:0];
      bdy = sq_data[NSq].pair.dy[32] ? 32'(-sq_data[NSq].pair.dy)
                                     : sq_data[NSq].pair.dy[31:0];
      d_in.pair     = sq_data[NSq].pair;
      d_in.pair.ok  = sq_data[NSq].pair.ok
                      && (sq_data[NSq].root <= sq_data[NSq].pair.sumr);
      d_in.distance = sq_data[NSq].root;
      d_in.rem_x    = {1'b0, bdx[31:1]};
      d_in.rem_y    = {1'b0, bdy[31:1]};
      d_in.nbit_x   = bdx[0];
      d_in.nbit_y   = bdy[0];
      d_in.q_x      = '0;
      d_in.q_y      = '0;
   end

   assign dv_data[0]  = d_ff;
   assign dv_valid[0] = d_v_ff;

   for (genvar j = 0; j < NDv; j++) begin : g_div
      cpcr_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_valid[j]),
         .in_data   (dv_data[j]),
         .out_valid (dv_valid[j+1]),
         .out_data  (dv_data[j+1])
      );
   end

   // normal and relative velocity projections
   always_comb begin
      e_in.pair = dv_data[NDv].pair;
      e_in.nx   = dv_data[NDv].pair.dx[32] ? -$signed({1'b0, dv_data[NDv].q_x})
                                           : $signed({1'b0, dv_data[NDv].q_x});
      e_in.ny   = dv_data[NDv].pair.dy[32] ? -$signed({1'b0, dv_data[NDv].q_y})
                                           : $signed({1'b0, dv_data[NDv].q_y});
      e_in.px   = 65'(dv_data[NDv].pair.rvx) * 65'(e_in.nx);
      e_in.py   = 65'(dv_data[NDv].pair.rvy) * 65'(e_in.ny);
      e_in.ov   = $signed({2'b00, 32'(dv_data[NDv].pair.sumr - dv_data[NDv].distance)});
   end

   // dot product and normal speed
   always_comb begin
      dot     = 66'(e_ff.px) + 66'(e_ff.py);
      dot_rnd = dot + (dot[65] ? 66'sd1073741823 : 66'sd0);
      f_in.pair = e_ff.pair;
      f_in.nx   = e_ff.nx;
      f_in.ny   = e_ff.ny;
      f_in.ov   = e_ff.ov;
      f_in.vn   = 36'(dot_rnd >>> 30);
      f_in.hit  = e_ff.pair.ok && (dot <= 66'sd0);
   end

   always_comb begin
      g_in.pair = f_ff.pair;
      g_in.hit  = f_ff.hit;
      g_in.mvx  = 68'(f_ff.nx) * 68'(f_ff.vn);
      g_in.mvy  = 68'(f_ff.ny) * 68'(f_ff.vn);
      g_in.mox  = 66'(f_ff.ov) * 66'(f_ff.nx);
      g_in.moy  = 66'(f_ff.ov) * 66'(f_ff.ny);
   end

   always_comb begin
      mvx_rnd = g_ff.mvx + (g_ff.mvx[67] ? 68'sd1073741823 : 68'sd0);
      mvy_rnd = g_ff.mvy + (g_ff.mvy[67] ? 68'sd1073741823 : 68'sd0);
      mox_rnd = g_ff.mox + (g_ff.mox[65] ? 66'sd2147483647 : 66'sd0);
      moy_rnd = g_ff.moy + (g_ff.moy[65] ? 66'sd2147483647 : 66'sd0);
      h_in.pair = g_ff.pair;
      h_in.hit  = g_ff.hit;
      h_in.dvx  = 36'(mvx_rnd >>> 30);
      h_in.dvy  = 36'(mvy_rnd >>> 30);
      h_in.shx  = 34'(mox_rnd >>> 31);
      h_in.shy  = 34'(moy_rnd >>> 31);
   end

   // apply response with saturation
   always_comb begin
      o_pax = cpcr_pkg::sat32(37'(h_ff.pair.pax) - 37'(h_ff.shx));
      o_pay = cpcr_pkg::sat32(37'(h_ff.pair.pay) - 37'(h_ff.shy));
      o_vax = cpcr_pkg::sat32(37'(h_ff.pair.vax) + 37'(h_ff.dvx));
      o_vay = cpcr_pkg::sat32(37'(h_ff.pair.vay) + 37'(h_ff.dvy));
      o_pbx = cpcr_pkg::sat32(37'(h_ff.pair.pbx) + 37'(h_ff.shx));
      o_pby = cpcr_pkg::sat32(37'(h_ff.pair.pby) + 37'(h_ff.shy));
      o_vbx = cpcr_pkg::sat32(37'(h_ff.pair.vbx) - 37'(h_ff.dvx));
      o_vby = cpcr_pkg::sat32(37'(h_ff.pair.vby) - 37'(h_ff.dvy));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         c_v_ff       <= 1'b0;
         d_v_ff       <= 1'b0;
         e_v_ff       <= 1'b0;
         f_v_ff       <= 1'b0;
         g_v_ff       <= 1'b0;
         h_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         a_v_ff       <= req_valid;
         b_v_ff       <= a_v_ff;
         c_v_ff       <= b_v_ff;
         d_v_ff       <= sq_valid[NSq];
         e_v_ff       <= dv_valid[NDv];
         f_v_ff       <= e_v_ff;
         g_v_ff       <= f_v_ff;
         h_v_ff       <= g_v_ff;
         rsp_valid_ff <= h_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
         e_ff <= e_in;
         f_ff <= f_in;
         g_ff <= g_in;
         h_ff <= h_in;
         pax_ff <= h_ff.hit ? o_pax : h_ff.pair.pax;
         pay_ff <= h_ff.hit ? o_pay : h_ff.pair.pay;
         vax_ff <= h_ff.hit ? o_vax : h_ff.pair.vax;
         vay_ff <= h_ff.hit ? o_vay : h_ff.pair.vay;
         pbx_ff <= h_ff.hit ? o_pbx : h_ff.pair.pbx;
         pby_ff <= h_ff.hit ? o_pby : h_ff.pair.pby;
         vbx_ff <= h_ff.hit ? o_vbx : h_ff.pair.vbx;
         vby_ff <= h_ff.hit ? o_vby : h_ff.pair.vby;
         col_ff <= h_ff.hit;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_pos_a_x = pax_ff;
   assign rsp_new_pos_a_y = pay_ff;
   assign rsp_new_vel_a_x = vax_ff;
   assign rsp_new_vel_a_y = vay_ff;
   assign rsp_new_pos_b_x = pbx_ff;
   assign rsp_new_pos_b_y = pby_ff;
   assign rsp_new_vel_b_x = vbx_ff;
   assign rsp_new_vel_b_y = vby_ff;
   assign rsp_collided    = col_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cpcr_sqrt_step.sv =====
`default_nettype none

module cpcr_sqrt_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire cpcr_pkg::sqrt_type in_data,
   output logic                   out_valid,
   output cpcr_pkg::sqrt_type     out_data
);

   logic [34:0]        acc;
   logic [34:0]        trial;
   logic               ge;
   cpcr_pkg::sqrt_type data_in;
   cpcr_pkg::sqrt_type data_ff;
   logic               valid_ff;

   always_comb begin
      acc   = {in_data.rem, in_data.rad[63:62]};
      trial = {1'b0, in_data.root, 2'b01};
      ge    = (acc >= trial);
      data_in      = in_data;
      data_in.rad  = {in_data.rad[61:0], 2'b00};
      data_in.rem  = ge ? 33'(acc - trial) : acc[32:0];
      data_in.root = {in_data.root[30:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cpcr_div_step.sv =====
`default_nettype none

module cpcr_div_step (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire cpcr_pkg::div_type in_data,
   output logic                  out_valid,
   output cpcr_pkg::div_type     out_data
);

   logic [32:0]       acc_x;
   logic [32:0]       acc_y;
   logic [32:0]       dvs;
   logic              ge_x;
   logic              ge_y;
   cpcr_pkg::div_type data_in;
   cpcr_pkg::div_type data_ff;
   logic              valid_ff;

   always_comb begin
      acc_x = {in_data.rem_x, in_data.nbit_x};
      acc_y = {in_data.rem_y, in_data.nbit_y};
      dvs   = {1'b0, in_data.distance};
      ge_x  = (acc_x >= dvs);
      ge_y  = (acc_y >= dvs);
      data_in        = in_data;
      data_in.rem_x  = ge_x ? 32'(acc_x - dvs) : acc_x[31:0];
      data_in.rem_y  = ge_y ? 32'(acc_y - dvs) : acc_y[31:0];
      data_in.nbit_x = 1'b0;
      data_in.nbit_y = 1'b0;
      data_in.q_x    = {in_data.q_x[29:0], ge_x};
      data_in.q_y    = {in_data.q_y[29:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

   typedef struct {
      logic signed [31:0] pax, pay, vax, vay;
      logic        [30:0] ra;
      logic signed [31:0] pbx, pby, vbx, vby;
      logic        [30:0] rb;
   } pair_req_type;

   typedef struct {
      logic signed [31:0] pax, pay, vax, vay, pbx, pby, vbx, vby;
      logic               hit;
   } pair_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_pos_a_x = '0, req_pos_a_y = '0, req_vel_a_x = '0, req_vel_a_y = '0;
   logic        [30:0] req_radius_a = '0, req_radius_b = '0;
   logic signed [31:0] req_pos_b_x = '0, req_pos_b_y = '0, req_vel_b_x = '0, req_vel_b_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_new_pos_a_x, rsp_new_pos_a_y, rsp_new_vel_a_x, rsp_new_vel_a_y;
   logic signed [31:0] rsp_new_pos_b_x, rsp_new_pos_b_y, rsp_new_vel_b_x, rsp_new_vel_b_y;
   logic rsp_collided;

   circle_pair_collision_response u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pos_a_x(req_pos_a_x), .req_pos_a_y(req_pos_a_y),
      .req_vel_a_x(req_vel_a_x), .req_vel_a_y(req_vel_a_y), .req_radius_a(req_radius_a),
      .req_pos_b_x(req_pos_b_x), .req_pos_b_y(req_pos_b_y),
      .req_vel_b_x(req_vel_b_x), .req_vel_b_y(req_vel_b_y), .req_radius_b(req_radius_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_new_pos_a_x(rsp_new_pos_a_x), .rsp_new_pos_a_y(rsp_new_pos_a_y),
      .rsp_new_vel_a_x(rsp_new_vel_a_x), .rsp_new_vel_a_y(rsp_new_vel_a_y),
      .rsp_new_pos_b_x(rsp_new_pos_b_x), .rsp_new_pos_b_y(rsp_new_pos_b_y),
      .rsp_new_vel_b_x(rsp_new_vel_b_x), .rsp_new_vel_b_y(rsp_new_vel_b_y),
      .rsp_collided(rsp_collided)
   );

   localparam int Latency = 72;
   localparam longint CycleLimit = 400000;

   pair_rsp_type expected_rsps[$];
   int mismatches = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_off = 1'b0;
   longint cycles = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] root;
      logic [63:0] bitv;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x = x - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic pair_rsp_type resolve_pair(input pair_req_type r);
      pair_rsp_type o;
      longint dx, dy, nx, ny, rvx, rvy, dot, vn, dvx, dvy, ov, shx, shy;
      logic [63:0] adx, ady, sqx, d2, distance, sumr;
      o.pax = r.pax; o.pay = r.pay; o.vax = r.vax; o.vay = r.vay;
      o.pbx = r.pbx; o.pby = r.pby; o.vbx = r.vbx; o.vby = r.vby;
      o.hit = 1'b0;
      dx = longint'(r.pbx) - longint'(r.pax);
      dy = longint'(r.pby) - longint'(r.pay);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      sqx = adx * adx;
      d2 = sqx + ady * ady;
      sumr = 64'(r.ra) + 64'(r.rb);
      if (d2 >= sqx && d2 != 0) begin
         distance = floor_sqrt(d2);
         if (distance <= sumr) begin
            nx = (dx * 64'sd1073741824) / longint'(distance);
            ny = (dy * 64'sd1073741824) / longint'(distance);
            rvx = longint'(r.vbx) - longint'(r.vax);
            rvy = longint'(r.vby) - longint'(r.vay);
            dot = rvx * nx + rvy * ny;
            if (dot <= 0) begin
               vn = dot / 64'sd1073741824;
               dvx = (nx * vn) / 64'sd1073741824;
               dvy = (ny * vn) / 64'sd1073741824;
               ov = longint'(sumr - distance);
               shx = (ov * nx) / 64'sd2147483648;
               shy = (ov * ny) / 64'sd2147483648;
               o.pax = clamp32(longint'(r.pax) - shx);
               o.pay = clamp32(longint'(r.pay) - shy);
               o.vax = clamp32(longint'(r.vax) + dvx);
               o.vay = clamp32(longint'(r.vay) + dvy);
               o.pbx = clamp32(longint'(r.pbx) + shx);
               o.pby = clamp32(longint'(r.pby) + shy);
               o.vbx = clamp32(longint'(r.vbx) - dvx);
               o.vby = clamp32(longint'(r.vby) - dvy);
               o.hit = 1'b1;
            end
         end
      end
      return o;
   endfunction

   task automatic send_pair(input pair_req_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
         gap++;
      end
      req_valid <= 1'b1;
      req_pos_a_x <= r.pax; req_pos_a_y <= r.pay;
      req_vel_a_x <= r.vax; req_vel_a_y <= r.vay; req_radius_a <= r.ra;
      req_pos_b_x <= r.pbx; req_pos_b_y <= r.pby;
      req_vel_b_x <= r.vbx; req_vel_b_y <= r.vby; req_radius_b <= r.rb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsps.push_back(resolve_pair(r));
   endtask

   function automatic logic signed [31:0] rand_coord(input int scale);
      case (scale)
         0: return $signed($urandom_range(4000)) - 2000;
         1: return $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
         2: return $signed($urandom_range(32'h3fff_ffff)) - 32'sh2000_0000;
         default: return $urandom;
      endcase
   endfunction

   // mostly near pairs so the collision path is exercised
   function automatic pair_req_type rand_pair();
      pair_req_type r;
      int sc;
      logic signed [31:0] span;
      sc = $urandom_range(9);
      sc = sc < 4 ? 1 : sc < 7 ? 2 : sc < 8 ? 0 : 3;
      r.pax = rand_coord(sc == 3 ? 3 : $urandom_range(3));
      r.pay = rand_coord(sc == 3 ? 3 : $urandom_range(3));
      span = rand_coord(sc);
      r.pbx = $urandom_range(4) == 0 ? $urandom : r.pax + span;
      r.pby = $urandom_range(4) == 0 ? $urandom : r.pay + rand_coord(sc);
      r.vax = rand_coord($urandom_range(3));
      r.vay = rand_coord($urandom_range(3));
      r.vbx = rand_coord($urandom_range(3));
      r.vby = rand_coord($urandom_range(3));
      if ($urandom_range(5) == 0) begin
         r.ra = 31'($urandom); r.rb = 31'($urandom);
      end else begin
         r.ra = 31'($urandom_range(span < 0 ? -span : span));
         r.rb = 31'($urandom_range(span < 0 ? -span : span));
         if (sc == 3) begin
            r.ra = r.ra >> 1; r.rb = r.rb >> 1;
         end
      end
      return r;
   endfunction

   // receiver side
   initial begin
      int held;
      pair_rsp_type e;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("tb_top NOT OK");
            $finish;
         end
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response");
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_new_pos_a_x !== e.pax || rsp_new_pos_a_y !== e.pay ||
                   rsp_new_vel_a_x !== e.vax || rsp_new_vel_a_y !== e.vay ||
                   rsp_new_pos_b_x !== e.pbx || rsp_new_pos_b_y !== e.pby ||
                   rsp_new_vel_b_x !== e.vbx || rsp_new_vel_b_y !== e.vby ||
                   rsp_collided !== e.hit) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch exp %h %h %h %h %h %h %h %h %b",
                               " got %h %h %h %h %h %h %h %h %b"},
                        e.pax, e.pay, e.vax, e.vay, e.pbx, e.pby, e.vbx, e.vby, e.hit,
                        rsp_new_pos_a_x, rsp_new_pos_a_y, rsp_new_vel_a_x, rsp_new_vel_a_y,
                        rsp_new_pos_b_x, rsp_new_pos_b_y, rsp_new_vel_b_x, rsp_new_vel_b_y,
                        rsp_collided);
               end
            end
         end
         if (hold_off) begin
            held++;
            rsp_stall <= held < 300;
            if (held >= 300) hold_off = 1'b0;
         end else begin
            held = 0;
            rsp_stall <= $urandom_range(99) < stall_pct;
         end
      end
   end

   typedef struct {
      pair_req_type r;
      bit           known;
      pair_rsp_type x;
   } stim_row_type;

   initial begin
      stim_row_type rows[$];
      stim_row_type s;
      pair_req_type r;
      pair_rsp_type e;
      int phase;
      int waited;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // coincident centres: passes through
      s.r = '{32'sd65536, -32'sd65536, 32'sd7, -32'sd7, 31'h7fffffff,
              32'sd65536, -32'sd65536, -32'sd9, 32'sd9, 31'h7fffffff};
      s.known = 1; s.x = '{32'sd65536, -32'sd65536, 32'sd7, -32'sd7,
                          32'sd65536, -32'sd65536, -32'sd9, 32'sd9, 1'b0};
      rows.push_back(s);
      // extremes, far apart
      s.r = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 31'h0,
              32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 31'h0};
      s.x = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0};
      rows.push_back(s);
      // apart, radii zero
      s.r = '{0, 0, 1, 1, 0, 32'sd65536, 0, -1, -1, 0};
      s.x = '{0, 0, 1, 1, 32'sd65536, 0, -1, -1, 1'b0};
      rows.push_back(s);
      s.known = 0;
      // touching exactly, head-on
      s.r = '{0, 0, 32'sd65536, 0, 31'd32768, 32'sd65536, 0, -32'sd65536, 0, 31'd32768};
      rows.push_back(s);
      // overlapping, approaching
      s.r = '{0, 0, 32'sd65536, 32'sd1000, 31'd65536, 32'sd65536, 32'sd30000, 0, 0, 31'd65536};
      rows.push_back(s);
      // overlapping but separating
      s.r = '{0, 0, -32'sd65536, 0, 31'd65536, 32'sd65536, 0, 32'sd65536, 0, 31'd65536};
      rows.push_back(s);
      // huge radii, saturating velocities and shifts
      s.r = '{32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff,
              32'sh7fffffff, 0, 32'sh80000000, 32'sh80000000, 31'h7fffffff};
      rows.push_back(s);
      s.r = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff,
              32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 31'h7fffffff};
      rows.push_back(s);
      // diagonal overlap, negative differences
      s.r = '{32'sd100000, 32'sd100000, -32'sd5000, 32'sd20, 31'd90000,
              32'sd10000, 32'sd20000, 32'sd5000, 32'sd3000, 31'd70000};
      rows.push_back(s);
      s.r = '{-32'sd1, -32'sd1, 32'sd1, 32'sd1, 31'd1, 0, 0, 0, 0, 31'd1};
      rows.push_back(s);

      foreach (rows[i]) begin
         send_pair(rows[i].r);
         if (rows[i].known) begin
            void'(expected_rsps.pop_back());
            expected_rsps.push_back(rows[i].x);
         end
      end

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            3: begin idle_pct = 14; stall_pct = 14; hold_off = 1'b1; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         repeat (330) send_pair(rand_pair());
      end
      req_valid <= 1'b0;

      waited = 0;
      while (expected_rsps.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (Latency + 10) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
